// ===== hw/rtl/bis_pkg.sv =====
// Package for the binary insertion sorter.
// Holds shared constants, codes, the cell control struct and the compare key function.
// No dependencies.
package bis_pkg;

  localparam int DATA_W       = 64;
  localparam int MAX_ELEM_DEF = 64;

  // Configuration register indexes
  localparam logic CFG_SORT_ORDER = 1'b0;
  localparam logic CFG_SIGNED     = 1'b1;

  // sort_order codes; the unused code 3 behaves as arrival order
  localparam logic [1:0] ORD_ASC     = 2'd0;
  localparam logic [1:0] ORD_DESC    = 2'd1;
  localparam logic [1:0] ORD_ARRIVAL = 2'd2;

  typedef enum logic [1:0] {
    ST_LOAD,
    ST_SORT,
    ST_EMIT
  } state_t;

  // Control broadcast to every cell in the chain
  typedef struct packed {
    logic load;   // write input word into the cell addressed by fill
    logic sort;   // odd-even compare-exchange step
    logic phase;  // which pairs exchange this step: cells with index parity == phase
    logic shift;  // move every word one cell toward cell 0
    logic sgn;    // two's complement compare
    logic desc;   // descending order
  } cell_ctl_t;

  // Key whose unsigned order matches the selected compare
  function automatic logic [DATA_W-1:0] order_key(input logic [DATA_W-1:0] v,
                                                  input logic sgn);
    order_key = v ^ {sgn, {(DATA_W-1){1'b0}}};
  endfunction

endpackage

// ===== hw/rtl/bis_cell.sv =====
// One storage cell of the sorting chain.
// Holds one word, exchanges with its upper neighbor during sort and shifts down on emit.
// Depends on bis_pkg.
module bis_cell
  import bis_pkg::*;
#(
  parameter int IDX = 0,
  parameter int CW  = 7
) (
  input  logic              clk,
  input  cell_ctl_t         ctl,
  input  logic [CW-1:0]     fill,
  input  logic [DATA_W-1:0] in_value,
  input  logic [DATA_W-1:0] lo_value,
  input  logic              lo_swap,
  input  logic [DATA_W-1:0] hi_value,
  output logic              swap,
  output logic [DATA_W-1:0] value
);

  logic              pair_active;
  logic [DATA_W-1:0] key_self;
  logic [DATA_W-1:0] key_hi;
  logic [DATA_W-1:0] value_next;

  // pair (IDX, IDX+1) takes part only when both cells hold set members
  assign pair_active = ctl.sort && (1'(IDX % 2) == ctl.phase) && (fill > CW'(IDX + 1));
  assign key_self    = order_key(value, ctl.sgn);
  assign key_hi      = order_key(hi_value, ctl.sgn);
  assign swap        = pair_active && (ctl.desc ? (key_self < key_hi) : (key_self > key_hi));

  always_comb begin
    value_next = value;
    if (ctl.load && (fill == CW'(IDX))) begin
      value_next = in_value;
    end else if (swap) begin
      value_next = hi_value;
    end else if (lo_swap) begin
      value_next = lo_value;
    end else if (ctl.shift) begin
      value_next = hi_value;
    end
  end

  always_ff @(posedge clk) begin
    value <= value_next;
  end

endmodule

// ===== hw/rtl/binary_insertion_sorter.sv =====
// Binary insertion sorter: collects up to MAX_ELEMENTS 64-bit words, then emits them ordered.
// Load: one input transaction per cycle, words land in arrival order in a chain of cells.
// Sort: MAX_ELEMENTS steps of odd-even transposition across the chain (skipped in arrival mode).
// Emit: one output transaction per cycle from cell 0, unless m_axis_tready stalls the output, while the
// chain shifts down; the words leave through one output register stage.
// Reset (rst, synchronous) empties the set, clears the pending drop flag and sets both config registers to zero.
module binary_insertion_sorter
  import bis_pkg::*;
#(
  parameter int MAX_ELEMENTS = MAX_ELEM_DEF
) (
  input  logic              clk,
  input  logic              rst,
  // configuration write channel
  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  logic              cfg_index,     // 0 sort_order, 1 signed_compare
  input  logic [1:0]        cfg_data,
  // input stream
  input  logic              s_axis_tvalid,
  output logic              s_axis_tready,
  input  logic [DATA_W-1:0] s_axis_tdata,  // [63:0] in_value
  input  logic              s_axis_tlast,  // in_last
  // output stream
  output logic              m_axis_tvalid,
  input  logic              m_axis_tready,
  output logic [DATA_W-1:0] m_axis_tdata,  // [63:0] out_value
  output logic              m_axis_tlast,  // out_last
  output logic              m_axis_tuser   // [0] overflow
);

  localparam int CW = $clog2(MAX_ELEMENTS + 1);  // fill count width
  localparam int SW = $clog2(MAX_ELEMENTS);      // sort step counter width

  // configuration registers
  logic [1:0] sort_order;
  logic       signed_compare;

  // set control
  state_t        state, state_next;
  logic [CW-1:0] fill, fill_next;
  logic          dropped, dropped_next;
  logic [SW-1:0] step, step_next;
  logic          mode_desc, mode_desc_next;
  logic          mode_sgn, mode_sgn_next;
  logic          ovf, ovf_next;

  // output register
  logic              out_valid_next;
  logic [DATA_W-1:0] out_data_next;
  logic              out_last_next;
  logic              out_user_next;

  logic      in_acc;
  logic      full;
  logic      emit;
  cell_ctl_t ctl;

  logic [DATA_W-1:0] cval  [MAX_ELEMENTS];
  logic              cswap [MAX_ELEMENTS];

  assign cfg_ready     = 1'b1;
  assign s_axis_tready = (state == ST_LOAD);
  assign in_acc        = s_axis_tvalid && s_axis_tready;
  assign full          = (fill == CW'(MAX_ELEMENTS));
  // emit a word when the output register is free or being drained
  assign emit          = (state == ST_EMIT) && (!m_axis_tvalid || m_axis_tready);

  // configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      sort_order     <= ORD_ASC;
      signed_compare <= 1'b0;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        CFG_SORT_ORDER: sort_order     <= cfg_data;
        CFG_SIGNED:     signed_compare <= cfg_data[0];
        default:        ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= ST_LOAD;
      fill          <= '0;
      dropped       <= 1'b0;
      step          <= '0;
      m_axis_tvalid <= 1'b0;
    end else begin
      state         <= state_next;
      fill          <= fill_next;
      dropped       <= dropped_next;
      step          <= step_next;
      m_axis_tvalid <= out_valid_next;
    end
  end

  // payload and mode registers need no reset
  always_ff @(posedge clk) begin
    mode_desc    <= mode_desc_next;
    mode_sgn     <= mode_sgn_next;
    ovf          <= ovf_next;
    m_axis_tdata <= out_data_next;
    m_axis_tlast <= out_last_next;
    m_axis_tuser <= out_user_next;
  end

  always_comb begin
    state_next     = state;
    fill_next      = fill;
    dropped_next   = dropped;
    step_next      = step;
    mode_desc_next = mode_desc;
    mode_sgn_next  = mode_sgn;
    ovf_next       = ovf;
    out_valid_next = m_axis_tvalid && !m_axis_tready;
    out_data_next  = m_axis_tdata;
    out_last_next  = m_axis_tlast;
    out_user_next  = m_axis_tuser;
    ctl            = '0;
    ctl.sgn        = mode_sgn;
    ctl.desc       = mode_desc;
    ctl.phase      = step[0];

    unique case (state)
      ST_LOAD: begin
        if (in_acc) begin
          if (full) begin
            dropped_next = 1'b1;
          end else begin
            ctl.load  = 1'b1;
            fill_next = fill + CW'(1);
          end
          if (s_axis_tlast) begin
            // registers take effect as of the last word of the set
            ovf_next       = dropped || full;
            dropped_next   = 1'b0;
            mode_desc_next = (sort_order == ORD_DESC);
            mode_sgn_next  = signed_compare;
            step_next      = '0;
            if (sort_order == ORD_ASC || sort_order == ORD_DESC) begin
              state_next = ST_SORT;
            end else begin
              state_next = ST_EMIT;
            end
          end
        end
      end
      ST_SORT: begin
        ctl.sort  = 1'b1;
        step_next = step + SW'(1);
        if (step == SW'(MAX_ELEMENTS - 1)) begin
          state_next = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (emit) begin
          ctl.shift      = 1'b1;
          out_valid_next = 1'b1;
          out_data_next  = cval[0];
          out_last_next  = (fill == CW'(1));
          out_user_next  = ovf;
          fill_next      = fill - CW'(1);
          if (fill == CW'(1)) begin
            state_next = ST_LOAD;
          end
        end
      end
      default: state_next = ST_LOAD;
    endcase
  end

  // chain of cells: cell i exchanges with cell i+1, emission shifts toward cell 0
  for (genvar i = 0; i < MAX_ELEMENTS; i++) begin : g_cell
    logic [DATA_W-1:0] lo_v;
    logic              lo_s;
    logic [DATA_W-1:0] hi_v;

    if (i == 0) begin : g_bottom
      assign lo_v = cval[i];
      assign lo_s = 1'b0;
    end else begin : g_mid_lo
      assign lo_v = cval[i-1];
      assign lo_s = cswap[i-1];
    end

    if (i == MAX_ELEMENTS - 1) begin : g_top
      assign hi_v = cval[i];
    end else begin : g_mid_hi
      assign hi_v = cval[i+1];
    end

    bis_cell #(
      .IDX (i),
      .CW  (CW)
    ) u_cell (
      .clk      (clk),
      .ctl      (ctl),
      .fill     (fill),
      .in_value (s_axis_tdata),
      .lo_value (lo_v),
      .lo_swap  (lo_s),
      .hi_value (hi_v),
      .swap     (cswap[i]),
      .value    (cval[i])
    );
  end

  // emission never runs on an empty set
  a_emit_nonempty: assert property (@(posedge clk) disable iff (rst)
    (state == ST_EMIT) |-> (fill != '0))
    else $error("emit state with empty set");

  // a word arriving at a full store is dropped and remembered
  a_drop_flag: assert property (@(posedge clk) disable iff (rst)
    (in_acc && !s_axis_tlast && full) |=> (dropped && full))
    else $error("dropped word not flagged");

  // final word of the set leaves the block empty and ready to load
  a_set_done: assert property (@(posedge clk) disable iff (rst)
    (emit && (fill == CW'(1))) |=> (state == ST_LOAD && fill == '0 && m_axis_tlast))
    else $error("set did not finish cleanly");

  // the fill count never exceeds capacity
  a_fill_cap: assert property (@(posedge clk) disable iff (rst)
    fill <= CW'(MAX_ELEMENTS))
    else $error("fill count beyond capacity");

endmodule
